FILE: rtl/core/pjb_pkg.sv
// ----------------------------------------------------------------------------
// pjb_pkg
// Shared types and constants of the per-slot input jitter buffer.
// ----------------------------------------------------------------------------
package pjb_pkg;

    localparam int CMD_W     = 2;
    localparam int SLOT_IN_W = 8;
    localparam int SEQ_W     = 32;
    localparam int WORD_W    = 32;
    localparam int STATUS_W  = 3;
    localparam int CNT_W     = 3;

    typedef enum logic [CMD_W-1:0] {
        CMD_JOIN  = 2'd0,
        CMD_LEAVE = 2'd1,
        CMD_PUSH  = 2'd2,
        CMD_POP   = 2'd3
    } t_cmd;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE    = 3'd0,
        ST_NO_SLOT = 3'd1,
        ST_ACTIVE  = 3'd2,
        ST_DEAD    = 3'd3,
        ST_STALE   = 3'd4,
        ST_DROPPED = 3'd5,
        ST_EMPTY   = 3'd6
    } t_status;

    // controller to datapath
    typedef struct packed {
        logic capture;
        logic ring_rd;
        logic commit;
    } t_ctrl_cmd;

    // datapath to controller
    typedef struct packed {
        logic need_ring;
        logic out_stall;
    } t_dp_stat;

endpackage

FILE: rtl/core/pjb_controller.sv
// ----------------------------------------------------------------------------
// pjb_controller
// Sequences one command through slot read, ring read and commit.
// ----------------------------------------------------------------------------
module pjb_controller
    import pjb_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_ready,
    input  t_dp_stat  i_stat,
    output t_ctrl_cmd o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_EVAL  = 3'b010,
        S_WRITE = 3'b100
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state       = r_state;
        o_ready       = 1'b0;
        o_cmd.capture = 1'b0;
        o_cmd.ring_rd = 1'b0;
        o_cmd.commit  = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_EVAL;
                end
            end
            S_EVAL: begin
                // slot state is valid here, fetch the head entry for a pop
                o_cmd.ring_rd = i_stat.need_ring;
                n_state       = S_WRITE;
            end
            S_WRITE: begin
                if (!i_stat.out_stall) begin
                    o_cmd.commit = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

FILE: rtl/core/pjb_datapath.sv
// ----------------------------------------------------------------------------
// pjb_datapath
// Slot state memories, ring memories, command evaluation and result register.
// ----------------------------------------------------------------------------
module pjb_datapath
    import pjb_pkg::*;
#(
    parameter int SLOT_COUNT = 8,
    parameter int RING_DEPTH = 4
)
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_ctrl_cmd            i_cmd,
    output t_dp_stat             o_stat,
    input  logic [CMD_W-1:0]     i_command,
    input  logic [SLOT_IN_W-1:0] i_player_slot,
    input  logic                 i_player_alive,
    input  logic [SEQ_W-1:0]     i_sequence_req,
    input  logic [WORD_W-1:0]    i_input_word,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic [STATUS_W-1:0]  o_status,
    output logic [WORD_W-1:0]    o_applied_word,
    output logic [SEQ_W-1:0]     o_ack_sequence,
    output logic [CNT_W-1:0]     o_buffered_count
);

    localparam int SLOT_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int HEAD_W = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam int FILL_W = $clog2(RING_DEPTH + 1);
    localparam int SUM_W  = FILL_W + 1;
    localparam int RING_N = SLOT_COUNT * RING_DEPTH;
    localparam int ADDR_W = (RING_N > 1) ? $clog2(RING_N) : 1;
    localparam logic [HEAD_W-1:0] LAST_HEAD = HEAD_W'(RING_DEPTH - 1);
    localparam logic [FILL_W-1:0] FULL_FILL = FILL_W'(RING_DEPTH);
    localparam logic [FILL_W-1:0] DROP_FILL = FILL_W'(RING_DEPTH - 1);

    // captured command
    t_cmd                 r_cmd;
    logic [SLOT_IN_W-1:0] r_slot;
    logic                 r_alive;
    logic [SEQ_W-1:0]     r_seq;
    logic [WORD_W-1:0]    r_word;

    // per-slot state, active bit doubles as the valid bit of the slot memories
    logic [SLOT_COUNT-1:0] r_active;
    logic [SEQ_W-1:0]      r_mem_newest [SLOT_COUNT];
    logic [SEQ_W-1:0]      r_mem_ack    [SLOT_COUNT];
    logic [HEAD_W-1:0]     r_mem_head   [SLOT_COUNT];
    logic [FILL_W-1:0]     r_mem_fill   [SLOT_COUNT];
    logic [SEQ_W-1:0]      r_m_newest;
    logic [SEQ_W-1:0]      r_m_ack;
    logic [HEAD_W-1:0]     r_m_head;
    logic [FILL_W-1:0]     r_m_fill;

    // ring entries of all slots
    logic [WORD_W-1:0] r_ring_word [RING_N];
    logic [SEQ_W-1:0]  r_ring_seq  [RING_N];
    logic [WORD_W-1:0] r_rd_word;
    logic [SEQ_W-1:0]  r_rd_seq;

    // result register
    logic               r_o_valid;
    t_status            r_o_status;
    logic [WORD_W-1:0]  r_o_word;
    logic [SEQ_W-1:0]   r_o_ack;
    logic [CNT_W-1:0]   r_o_cnt;

    logic                      in_range;
    logic [SLOT_W-1:0]         sidx;
    logic                      act;
    logic [SEQ_W-1:0]          cur_newest;
    logic [SEQ_W-1:0]          cur_ack;
    logic [HEAD_W-1:0]         cur_head;
    logic [FILL_W-1:0]         cur_fill;
    logic [HEAD_W-1:0]         head_inc;
    logic                      full;
    logic [HEAD_W-1:0]         push_head;
    logic [FILL_W-1:0]         push_fill;
    logic [SUM_W-1:0]          pos_sum;
    logic [SUM_W-1:0]          pos_wrap;
    logic [HEAD_W-1:0]         push_pos;
    logic [ADDR_W:0]           ring_base;
    logic [ADDR_W-1:0]         addr_push;
    logic [ADDR_W-1:0]         addr_pop;

    t_status                   res_status;
    logic [WORD_W-1:0]         res_word;
    logic [SEQ_W-1:0]          res_ack;
    logic [FILL_W-1:0]         res_fill;
    logic [FILL_W+CNT_W-1:0]   res_fill_ext;
    logic                      wr_meta;
    logic                      wr_ring;
    logic                      set_active;
    logic                      clr_active;
    logic                      need_ring;
    logic [SEQ_W-1:0]          new_newest;
    logic [SEQ_W-1:0]          new_ack;
    logic [HEAD_W-1:0]         new_head;
    logic [FILL_W-1:0]         new_fill;

    // command capture and slot state read
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_cmd      <= t_cmd'(i_command);
            r_slot     <= i_player_slot;
            r_alive    <= i_player_alive;
            r_seq      <= i_sequence_req;
            r_word     <= i_input_word;
            r_m_newest <= r_mem_newest[i_player_slot[SLOT_W-1:0]];
            r_m_ack    <= r_mem_ack[i_player_slot[SLOT_W-1:0]];
            r_m_head   <= r_mem_head[i_player_slot[SLOT_W-1:0]];
            r_m_fill   <= r_mem_fill[i_player_slot[SLOT_W-1:0]];
        end
    end

    assign in_range   = {1'b0, r_slot} < (SLOT_IN_W + 1)'(SLOT_COUNT);
    assign sidx       = r_slot[SLOT_W-1:0];
    assign act        = in_range && r_active[sidx];
    // an inactive slot reads as cleared
    assign cur_newest = act ? r_m_newest : '0;
    assign cur_ack    = act ? r_m_ack    : '0;
    assign cur_head   = act ? r_m_head   : '0;
    assign cur_fill   = act ? r_m_fill   : '0;

    assign head_inc  = (cur_head == LAST_HEAD) ? '0 : cur_head + 1'b1;
    assign full      = (cur_fill == FULL_FILL);
    assign push_head = full ? head_inc  : cur_head;
    assign push_fill = full ? DROP_FILL : cur_fill;
    assign pos_sum   = SUM_W'(push_head) + SUM_W'(push_fill);
    assign pos_wrap  = (pos_sum >= SUM_W'(RING_DEPTH)) ? pos_sum - SUM_W'(RING_DEPTH) : pos_sum;
    assign push_pos  = pos_wrap[HEAD_W-1:0];

    assign ring_base = (ADDR_W + 1)'(sidx) * (ADDR_W + 1)'(RING_DEPTH);
    assign addr_push = ADDR_W'(ring_base + (ADDR_W + 1)'(push_pos));
    assign addr_pop  = ADDR_W'(ring_base + (ADDR_W + 1)'(cur_head));

    always_comb begin
        res_status = ST_DONE;
        res_word   = '0;
        res_ack    = cur_ack;
        res_fill   = cur_fill;
        wr_meta    = 1'b0;
        wr_ring    = 1'b0;
        set_active = 1'b0;
        clr_active = 1'b0;
        need_ring  = 1'b0;
        new_newest = cur_newest;
        new_ack    = cur_ack;
        new_head   = cur_head;
        new_fill   = cur_fill;
        if (!in_range) begin
            res_status = ST_NO_SLOT;
            res_ack    = '0;
            res_fill   = '0;
        end else if (r_cmd == CMD_JOIN) begin
            if (act) begin
                res_status = ST_ACTIVE;
            end else begin
                set_active = 1'b1;
                wr_meta    = 1'b1;
                new_newest = '0;
                new_ack    = '0;
                new_head   = '0;
                new_fill   = '0;
            end
        end else if (!act) begin
            res_status = ST_NO_SLOT;
        end else begin
            case (r_cmd)
                CMD_LEAVE: begin
                    clr_active = 1'b1;
                    res_ack    = '0;
                    res_fill   = '0;
                end
                CMD_PUSH: begin
                    if (!r_alive) begin
                        res_status = ST_DEAD;
                    end else if (r_seq <= cur_newest) begin
                        res_status = ST_STALE;
                    end else begin
                        wr_meta    = 1'b1;
                        wr_ring    = 1'b1;
                        new_newest = r_seq;
                        new_head   = push_head;
                        new_fill   = push_fill + 1'b1;
                        res_fill   = push_fill + 1'b1;
                        if (full) begin
                            res_status = ST_DROPPED;
                        end
                    end
                end
                CMD_POP: begin
                    if (!r_alive) begin
                        res_status = ST_DEAD;
                    end else if (cur_fill == '0) begin
                        res_status = ST_EMPTY;
                    end else begin
                        need_ring = 1'b1;
                        wr_meta   = 1'b1;
                        res_word  = r_rd_word;
                        new_ack   = r_rd_seq;
                        res_ack   = r_rd_seq;
                        new_head  = head_inc;
                        new_fill  = cur_fill - 1'b1;
                        res_fill  = cur_fill - 1'b1;
                    end
                end
                default: begin
                    res_status = ST_DONE;
                end
            endcase
        end
    end

    assign res_fill_ext = (FILL_W + CNT_W)'(res_fill);

    // slot state write back
    always_ff @(posedge i_clk) begin
        if (i_cmd.commit && wr_meta) begin
            r_mem_newest[sidx] <= new_newest;
            r_mem_ack[sidx]    <= new_ack;
            r_mem_head[sidx]   <= new_head;
            r_mem_fill[sidx]   <= new_fill;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= '0;
        end else if (i_cmd.commit) begin
            if (set_active) begin
                r_active[sidx] <= 1'b1;
            end else if (clr_active) begin
                r_active[sidx] <= 1'b0;
            end
        end
    end

    // ring memory, one write and one registered read
    always_ff @(posedge i_clk) begin
        if (i_cmd.commit && wr_ring) begin
            r_ring_word[addr_push] <= r_word;
            r_ring_seq[addr_push]  <= r_seq;
        end
        if (i_cmd.ring_rd) begin
            r_rd_word <= r_ring_word[addr_pop];
            r_rd_seq  <= r_ring_seq[addr_pop];
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (i_cmd.commit) begin
            r_o_valid <= 1'b1;
        end else if (i_ready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_o_status <= res_status;
            r_o_word   <= res_word;
            r_o_ack    <= res_ack;
            r_o_cnt    <= res_fill_ext[CNT_W-1:0];
        end
    end

    assign o_stat.need_ring = need_ring;
    assign o_stat.out_stall = r_o_valid && !i_ready;

    assign o_valid          = r_o_valid;
    assign o_status         = r_o_status;
    assign o_applied_word   = r_o_word;
    assign o_ack_sequence   = r_o_ack;
    assign o_buffered_count = r_o_cnt;

endmodule

FILE: rtl/core/per_slot_input_jitter_buffer_unit.sv
// ----------------------------------------------------------------------------
// per_slot_input_jitter_buffer_unit
// Per-player rings of input words with sequence filtering and drop-oldest.
// ----------------------------------------------------------------------------
// Each accepted command (join, leave, push, pop) yields exactly one result
// beat. A command passes from acceptance to a valid result through these
// steps: read the slot's state memory, read the slot's ring memory at its
// head (used by a pop), and update both memories and load the result
// register. The input takes the next command once that result is loaded,
// so a new command is not accepted while one is in flight; a result that
// is not taken holds the next command in its commit cycle. After reset all
// slots are inactive and no clearing pass is needed. Slot ids at or above
// SLOT_COUNT answer "no such slot" with zero fields.
module per_slot_input_jitter_buffer_unit
    import pjb_pkg::*;
#(
    parameter int SLOT_COUNT = 8,
    parameter int RING_DEPTH = 4
)
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic [CMD_W-1:0]     i_command,
    input  logic [SLOT_IN_W-1:0] i_player_slot,
    input  logic                 i_player_alive,
    input  logic [SEQ_W-1:0]     i_sequence_req,
    input  logic [WORD_W-1:0]    i_input_word,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic [STATUS_W-1:0]  o_status,
    output logic [WORD_W-1:0]    o_applied_word,
    output logic [SEQ_W-1:0]     o_ack_sequence,
    output logic [CNT_W-1:0]     o_buffered_count
);

    t_ctrl_cmd ctrl_cmd;
    t_dp_stat  dp_stat;

    pjb_controller u_pjb_controller (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_stat  (dp_stat),
        .o_cmd   (ctrl_cmd)
    );

    pjb_datapath #(
        .SLOT_COUNT (SLOT_COUNT),
        .RING_DEPTH (RING_DEPTH)
    ) u_pjb_datapath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (ctrl_cmd),
        .o_stat           (dp_stat),
        .i_command        (i_command),
        .i_player_slot    (i_player_slot),
        .i_player_alive   (i_player_alive),
        .i_sequence_req   (i_sequence_req),
        .i_input_word     (i_input_word),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_status         (o_status),
        .o_applied_word   (o_applied_word),
        .o_ack_sequence   (o_ack_sequence),
        .o_buffered_count (o_buffered_count)
    );

endmodule

FILE: rtl/core/pjb_checker.sv
// ----------------------------------------------------------------------------
// pjb_checker
// Port-level checks of the result channel, bound to the top level.
// ----------------------------------------------------------------------------
module pjb_checker
    import pjb_pkg::*;
#(
    parameter int RING_DEPTH = 4
)
(
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                o_valid,
    input logic                i_ready,
    input logic [STATUS_W-1:0] o_status,
    input logic [WORD_W-1:0]   o_applied_word,
    input logic [SEQ_W-1:0]    o_ack_sequence,
    input logic [CNT_W-1:0]    o_buffered_count
);

    // stalled result beat holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_status)
            && $stable(o_applied_word) && $stable(o_ack_sequence)
            && $stable(o_buffered_count))
        else $error("result beat changed while stalled");

    // only a successful pop carries a word
    a_word_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status != ST_DONE |-> o_applied_word == '0)
        else $error("applied word on a command that took no entry");

    // a missing or inactive slot reports a cleared slot
    a_no_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status == ST_NO_SLOT |-> o_ack_sequence == '0
            && o_buffered_count == '0)
        else $error("no-slot result with nonzero slot fields");

    // fill never exceeds the ring depth
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (RING_DEPTH > 7) || (int'(o_buffered_count) <= RING_DEPTH))
        else $error("buffered count above ring depth");

endmodule

bind per_slot_input_jitter_buffer_unit pjb_checker #(
    .RING_DEPTH (RING_DEPTH)
) u_pjb_checker (.*);
